### rtl/jesv_pkg.sv
// Shared types, constants and helpers for the Julia escape smooth-value block.
// No dependencies.
package jesv_pkg;

  localparam int DIM_W   = 13;
  localparam int COORD_W = 32;
  localparam int NUM_W   = 38;   // (index * 3) << 24

  localparam logic signed [41:0] HALF3_Q24   = 42'sd25165824;
  localparam logic [63:0]        NORM_ESCAPE = 64'd30 << 48;

  localparam logic signed [31:0] C_RESET     = 32'sd0;
  localparam logic [12:0]        DIM_RESET   = 13'd1024;
  localparam logic [15:0]        LIMIT_RESET = 16'd256;

  localparam int EXP_TABLE_DEPTH_DEF = 1024;
  localparam int MAX_DIMENSION_DEF   = 4096;
  localparam int ITER_BITS_DEF       = 16;

  typedef enum logic [2:0] {
    REG_C_REAL = 3'd0,
    REG_C_IMAG = 3'd1,
    REG_WIDTH  = 3'd2,
    REG_HEIGHT = 3'd3,
    REG_LIMIT  = 3'd4
  } reg_index_t;

  typedef struct packed {
    logic signed [31:0] re;
    logic signed [31:0] im;
  } point_t;

  function automatic logic signed [31:0] sat32(input logic signed [41:0] v);
    logic signed [31:0] r;
    if (v > 42'sd2147483647) r = 32'sh7FFFFFFF;
    else if (v < -42'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

### rtl/jesv_front.sv
// Front end: accepts pixel items and maps them to start points with two
// bit-serial dividers. Depends on jesv_pkg.
module jesv_front (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [11:0]              row_index,
  input  logic [11:0]              col_index,
  input  logic [jesv_pkg::DIM_W-1:0] dim_x,
  input  logic [jesv_pkg::DIM_W-1:0] dim_y,
  output logic                     push,
  input  logic                     full,
  output jesv_pkg::point_t         push_data
);

  typedef enum logic [1:0] {F_IDLE, F_DIV, F_PUSH} fstate_t;

  fstate_t state;
  logic [5:0] cnt;
  logic [jesv_pkg::NUM_W-1:0] numx, numy, qx, qy;
  logic [jesv_pkg::DIM_W-1:0] rx, ry;
  logic [jesv_pkg::DIM_W:0]   tx, ty;
  logic gex, gey;
  logic signed [41:0] x_wide, y_wide;

  assign in_stall = (state != F_IDLE);

  assign tx  = {rx, numx[jesv_pkg::NUM_W-1]};
  assign ty  = {ry, numy[jesv_pkg::NUM_W-1]};
  assign gex = tx >= {1'b0, dim_x};
  assign gey = ty >= {1'b0, dim_y};

  // start point from the quotients, saturated to Q8.24
  assign x_wide = $signed({4'b0, qx}) - jesv_pkg::HALF3_Q24;
  assign y_wide = jesv_pkg::HALF3_Q24 - $signed({4'b0, qy});
  assign push_data.re = jesv_pkg::sat32(x_wide);
  assign push_data.im = jesv_pkg::sat32(y_wide);
  assign push = (state == F_PUSH) && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      cnt   <= '0;
    end else begin
      case (state)
        F_IDLE: begin
          if (in_valid) begin
            numx  <= {14'(col_index) * 14'd3, 24'b0};
            numy  <= {14'(row_index) * 14'd3, 24'b0};
            rx    <= '0;
            ry    <= '0;
            cnt   <= '0;
            state <= F_DIV;
          end
        end
        F_DIV: begin
          rx   <= gex ? jesv_pkg::DIM_W'(tx - {1'b0, dim_x}) : tx[jesv_pkg::DIM_W-1:0];
          ry   <= gey ? jesv_pkg::DIM_W'(ty - {1'b0, dim_y}) : ty[jesv_pkg::DIM_W-1:0];
          qx   <= {qx[jesv_pkg::NUM_W-2:0], gex};
          qy   <= {qy[jesv_pkg::NUM_W-2:0], gey};
          numx <= numx << 1;
          numy <= numy << 1;
          cnt  <= cnt + 6'd1;
          if (cnt == 6'(jesv_pkg::NUM_W - 1)) state <= F_PUSH;
        end
        F_PUSH: begin
          if (!full) state <= F_IDLE;
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

### rtl/jesv_queue.sv
// Two-entry queue of start points between front and back end.
// Depends on jesv_pkg.
module jesv_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  jesv_pkg::point_t push_data,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output jesv_pkg::point_t pop_data
);

  jesv_pkg::point_t mem [2];
  logic wptr, rptr;
  logic [1:0] count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign pop_data  = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= '0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop)  rptr <= ~rptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

### rtl/jesv_back.sv
// Back end: iterates z = z*z + c, sums exp(-|z|^2) from a table and divides
// the sum by the limit bit-serially. Depends on jesv_pkg.
module jesv_back #(
  parameter int EXP_TABLE_DEPTH = jesv_pkg::EXP_TABLE_DEPTH_DEF,
  parameter int ITER_BITS       = jesv_pkg::ITER_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_valid,
  input  jesv_pkg::point_t      q_data,
  output logic                  pop,
  input  logic signed [31:0]    c_real,
  input  logic signed [31:0]    c_imag,
  input  logic [ITER_BITS-1:0]  limit,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [16:0]           smooth_value
);

  localparam int LOG_D = $clog2(EXP_TABLE_DEPTH);
  localparam int SUM_W = ITER_BITS + 17;
  localparam int CNT_W = $clog2(SUM_W + 1);

  // exponent step 32/depth in Q0.32
  localparam logic [127:0] EXP_STEP = (128'd32 << 32) / EXP_TABLE_DEPTH;

  typedef logic [16:0] rom_t [EXP_TABLE_DEPTH];

  // quotient by a small divisor, shift and subtract
  function automatic logic [127:0] div_small(input logic [127:0] x, input logic [4:0] d);
    logic [127:0] q;
    logic [127:0] r;
    q = '0;
    r = '0;
    for (int b = 127; b >= 0; b--) begin
      r = {r[126:0], x[b]};
      if (r >= 128'(d)) begin
        r    = r - 128'(d);
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic rom_t build_rom();
    rom_t r;
    logic [127:0] e, term, v;
    e    = 128'd1 << 32;
    term = 128'd1 << 32;
    v    = 128'd1 << 32;
    for (int k = 1; k <= 24; k++) begin
      term = div_small((term * EXP_STEP) >> 32, 5'(k));
      if (k % 2 == 1) e = e - term;
      else e = e + term;
    end
    for (int i = 0; i < EXP_TABLE_DEPTH; i++) begin
      r[i] = 17'((v + 128'd32768) >> 16);
      v = ((v * e) >> 32) & 128'hFFFF_FFFF_FFFF_FFFF;
    end
    return r;
  endfunction

  localparam rom_t EXP_ROM = build_rom();

  typedef enum logic [2:0] {S_IDLE, S_MUL, S_UPD, S_ACC, S_DIV, S_DONE} bstate_t;

  bstate_t state;
  logic signed [31:0] re, im;
  logic signed [63:0] sr, si, pr;
  logic [ITER_BITS-1:0] n;
  logic [SUM_W-1:0] sum, dv;
  logic [ITER_BITS-1:0] rem;
  logic [CNT_W-1:0] dcnt;
  logic [16:0] rom_q;
  logic pend;

  logic [63:0] norm, idx_full;
  logic [LOG_D-1:0] idx;
  logic escape, last_pass;
  logic signed [41:0] nre, nim;
  logic [ITER_BITS:0] t;
  logic ge;
  logic load_out;

  assign pop = (state == S_IDLE) && q_valid;

  assign norm     = 64'(sr) + 64'(si);
  assign idx_full = norm >> (53 - LOG_D);
  assign idx      = (idx_full > 64'(EXP_TABLE_DEPTH - 1)) ? LOG_D'(EXP_TABLE_DEPTH - 1)
                                                         : idx_full[LOG_D-1:0];
  assign escape    = norm > jesv_pkg::NORM_ESCAPE;
  assign last_pass = ((ITER_BITS+1)'(n) + (ITER_BITS+1)'(1)) == {1'b0, limit};

  // floor division by arithmetic shift
  assign nre = 42'((65'(sr) - 65'(si)) >>> 24) + 42'(c_real);
  assign nim = 42'(pr >>> 23) + 42'(c_imag);

  assign t  = {rem, dv[SUM_W-1]};
  assign ge = t >= {1'b0, limit};

  assign load_out = (state == S_DONE) && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      pend      <= 1'b0;
    end else begin
      out_valid <= load_out || (out_valid && out_stall);
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            re   <= q_data.re;
            im   <= q_data.im;
            n    <= '0;
            sum  <= '0;
            pend <= 1'b0;
            if (limit == '0) begin
              dv    <= '0;
              state <= S_DONE;
            end else begin
              state <= S_MUL;
            end
          end
        end
        S_MUL: begin
          sr <= re * re;
          si <= im * im;
          pr <= re * im;
          if (pend) sum <= sum + SUM_W'(rom_q);
          pend  <= 1'b0;
          state <= S_UPD;
        end
        S_UPD: begin
          rom_q <= EXP_ROM[idx];
          pend  <= 1'b1;
          n     <= n + ITER_BITS'(1);
          re    <= jesv_pkg::sat32(nre);
          im    <= jesv_pkg::sat32(nim);
          state <= (escape || last_pass) ? S_ACC : S_MUL;
        end
        S_ACC: begin
          dv    <= sum + SUM_W'(rom_q);
          pend  <= 1'b0;
          rem   <= '0;
          dcnt  <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          rem  <= ge ? ITER_BITS'(t - {1'b0, limit}) : t[ITER_BITS-1:0];
          dv   <= {dv[SUM_W-2:0], ge};
          dcnt <= dcnt + CNT_W'(1);
          if (dcnt == CNT_W'(SUM_W - 1)) state <= S_DONE;
        end
        S_DONE: begin
          if (load_out) begin
            smooth_value <= dv[16:0];
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    pop |=> (state == S_MUL || state == S_DONE))
    else $error("pop did not start a pixel");

  a_pass_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_UPD) |-> ((ITER_BITS+1)'(n) < {1'b0, limit}))
    else $error("pass count beyond limit");

  a_result_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && (!out_valid || !out_stall)) |-> (dv <= SUM_W'(65536)))
    else $error("result above 1.0");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(smooth_value)))
    else $error("held result overwritten");

endmodule

### rtl/julia_escape_smooth_value.sv
// Julia escape smooth value: pixel (row, column) in, exp(-|z|^2) sum over the
// iteration limit out, Q1.16. Steps: bit-serial coordinate division, a queue
// hop, passes of z (one multiply, one update each) up to the limit or escape,
// then bit-serial division of the sum. One pixel at a time in the back end;
// the front end maps the next pixels meanwhile. Synchronous reset clears
// control and restores register defaults.
module julia_escape_smooth_value #(
  parameter int EXP_TABLE_DEPTH = jesv_pkg::EXP_TABLE_DEPTH_DEF,
  parameter int MAX_DIMENSION   = jesv_pkg::MAX_DIMENSION_DEF,
  parameter int ITER_BITS       = jesv_pkg::ITER_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [11:0] row_index,
  input  logic [11:0] col_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [16:0] smooth_value
);

  // largest usable dimension given the 13-bit registers
  localparam int DIM_CAP_I = (MAX_DIMENSION > 8191) ? 8191 : MAX_DIMENSION;
  localparam logic [jesv_pkg::DIM_W-1:0] DIM_CAP = jesv_pkg::DIM_W'(DIM_CAP_I);

  logic signed [31:0] c_real, c_imag;
  logic [12:0] image_width, image_height;
  logic [15:0] iteration_limit;

  logic [jesv_pkg::DIM_W-1:0] dim_x, dim_y;
  logic [ITER_BITS-1:0] limit_eff;

  logic             q_push, q_full, q_pop, q_valid;
  jesv_pkg::point_t q_in, q_out;

  // config registers; unknown indexes are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      c_real          <= jesv_pkg::C_RESET;
      c_imag          <= jesv_pkg::C_RESET;
      image_width     <= jesv_pkg::DIM_RESET;
      image_height    <= jesv_pkg::DIM_RESET;
      iteration_limit <= jesv_pkg::LIMIT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        jesv_pkg::REG_C_REAL: c_real          <= cfg_data;
        jesv_pkg::REG_C_IMAG: c_imag          <= cfg_data;
        jesv_pkg::REG_WIDTH:  image_width     <= cfg_data[12:0];
        jesv_pkg::REG_HEIGHT: image_height    <= cfg_data[12:0];
        jesv_pkg::REG_LIMIT:  iteration_limit <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // zero acts as one, oversize clamps to the cap
  assign dim_x = (image_width == '0) ? jesv_pkg::DIM_W'(1) :
                 (image_width > DIM_CAP) ? DIM_CAP : image_width;
  assign dim_y = (image_height == '0) ? jesv_pkg::DIM_W'(1) :
                 (image_height > DIM_CAP) ? DIM_CAP : image_height;
  assign limit_eff = ITER_BITS'(iteration_limit);

  jesv_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .row_index (row_index),
    .col_index (col_index),
    .dim_x     (dim_x),
    .dim_y     (dim_y),
    .push      (q_push),
    .full      (q_full),
    .push_data (q_in)
  );

  jesv_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .pop_data  (q_out)
  );

  jesv_back #(
    .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH),
    .ITER_BITS       (ITER_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_data       (q_out),
    .pop          (q_pop),
    .c_real       (c_real),
    .c_imag       (c_imag),
    .limit        (limit_eff),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .smooth_value (smooth_value)
  );

endmodule
